/* rtl/kthdt_pkg.sv */
package kthdt_pkg;

  localparam int DEF_POOL_SIZE  = 10;
  localparam int DEF_TIME_WIDTH = 16;

  localparam int CODE_W     = 16;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [MS_W-1:0] RST_DOUBLE_TAP_MS = 16'd300;
  localparam logic [MS_W-1:0] RST_HOLD_MS       = 16'd500;

  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 1'd1;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_WAIT_HOLD   = 2'd1,
    PH_WAIT_DOUBLE = 2'd2,
    PH_HELD        = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_HOLD    = 3'd2,
    EV_SINGLE  = 3'd3,
    EV_DOUBLE  = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_APPLY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_TICK  = 3'd1,
    ST_SCAN  = 3'd2,
    ST_APPLY = 3'd3,
    ST_FLUSH = 3'd4
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] act_id;
    logic              key_pressed;
    logic [MS_W-1:0]   double_tap_ms;
    logic [MS_W-1:0]   hold_ms;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic [2:0]        event_kind;
    logic              last;
  } out_word_t;

  // One tracker record, without its elapsed count (width set by a parameter).
  typedef struct packed {
    phase_t            phase;
    logic [CODE_W-1:0] action;
    logic [MS_W-1:0]   dbl_limit;
    logic [MS_W-1:0]   hold_limit;
  } track_t;

  // Control handed to the head unit for one record.
  typedef struct packed {
    mode_t             mode;
    logic              hit;
    logic              found;
    logic              pressed;
    logic [CODE_W-1:0] code;
    logic [MS_W-1:0]   dbl_limit;
    logic [MS_W-1:0]   hold_limit;
  } proc_ctl_t;

endpackage

/* rtl/kthdt_cell.sv */
module kthdt_cell #(
  parameter int TIME_WIDTH = kthdt_pkg::DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift,
  input  kthdt_pkg::track_t     rec_i,
  input  logic [TIME_WIDTH-1:0] el_i,
  output kthdt_pkg::track_t     rec_o,
  output logic [TIME_WIDTH-1:0] el_o
);
  import kthdt_pkg::*;

  phase_t                  phase_r;
  logic [CODE_W-1:0]       action_r;
  logic [TIME_WIDTH-1:0]   el_r;
  logic [MS_W-1:0]         dbl_r;
  logic [MS_W-1:0]         hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      action_r <= '0;
      el_r     <= '0;
    end else if (shift) begin
      phase_r  <= rec_i.phase;
      action_r <= rec_i.action;
      el_r     <= el_i;
    end
  end

  // Limits are only read while the tracker is active.
  always_ff @(posedge clk) begin
    if (shift) begin
      dbl_r  <= rec_i.dbl_limit;
      hold_r <= rec_i.hold_limit;
    end
  end

  assign rec_o = '{phase: phase_r, action: action_r, dbl_limit: dbl_r, hold_limit: hold_r};
  assign el_o  = el_r;

endmodule

/* rtl/kthdt_proc.sv */
module kthdt_proc #(
  parameter int TIME_WIDTH = kthdt_pkg::DEF_TIME_WIDTH
) (
  input  kthdt_pkg::proc_ctl_t  ctl,
  input  kthdt_pkg::track_t     rec_i,
  input  logic [TIME_WIDTH-1:0] el_i,
  output kthdt_pkg::track_t     rec_o,
  output logic [TIME_WIDTH-1:0] el_o,
  output logic                  emit_o,
  output kthdt_pkg::out_word_t  emit_word_o
);
  import kthdt_pkg::*;

  localparam int CW = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;

  logic [TIME_WIDTH-1:0] el_inc;
  logic [CW-1:0]         el_ext;
  logic [CW-1:0]         hold_ext;
  logic [CW-1:0]         dbl_ext;
  ev_kind_t              kind;

  assign el_inc   = (el_i == '1) ? el_i : el_i + 1'b1;
  assign el_ext   = CW'(el_inc);
  assign hold_ext = CW'(rec_i.hold_limit);
  assign dbl_ext  = CW'(rec_i.dbl_limit);

  always_comb begin
    rec_o  = rec_i;
    el_o   = el_i;
    emit_o = 1'b0;
    kind   = EV_HOLD;
    case (ctl.mode)
      MODE_TICK: begin
        el_o = el_inc;
        if (rec_i.phase == PH_WAIT_HOLD && el_ext >= hold_ext) begin
          emit_o      = 1'b1;
          kind        = EV_HOLD;
          rec_o.phase = PH_HELD;
        end else if (rec_i.phase == PH_WAIT_DOUBLE && el_ext >= dbl_ext) begin
          emit_o       = 1'b1;
          kind         = EV_SINGLE;
          rec_o.phase  = PH_IDLE;
          rec_o.action = '0;
        end
      end
      MODE_APPLY: begin
        if (ctl.hit) begin
          if (!ctl.found) begin
            // take a free tracker for a first press
            rec_o = '{phase: PH_WAIT_HOLD, action: ctl.code,
                      dbl_limit: ctl.dbl_limit, hold_limit: ctl.hold_limit};
            el_o  = '0;
          end else if (ctl.pressed) begin
            if (rec_i.phase == PH_WAIT_DOUBLE) begin
              emit_o       = 1'b1;
              kind         = EV_DOUBLE;
              rec_o.phase  = PH_IDLE;
              rec_o.action = '0;
            end
          end else if (rec_i.phase == PH_WAIT_HOLD) begin
            rec_o.phase = PH_WAIT_DOUBLE;
            el_o        = '0;
          end else if (rec_i.phase == PH_HELD) begin
            rec_o.phase  = PH_IDLE;
            rec_o.action = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign emit_word_o = '{event_code: rec_i.action, event_kind: kind, last: 1'b0};

endmodule

/* rtl/key_tap_hold_double_tap_tracker.sv */
// Tap / hold / double-tap tracker. The trackers sit in a ring of cells that
// rotates by one position per cycle past a single head unit at cell 0; one
// full rotation visits every tracker in order and leaves the ring as it was.
// A tick word passes through the accept, one rotation that ages every
// tracker and reports hold or single tap, then a closing step for the last
// result. A key word passes through the accept, one rotation that finds the
// tracker following the action and the lowest idle one, a second rotation
// that updates the chosen tracker, and the closing step. Press or release is
// always the first result of a key word; a double tap follows when a press
// lands in the released window. A press with no free tracker reports only the
// press. Each result waits in a holding stage so the final one can carry
// last; the rotation and the closing step stall while the result port is
// backed up. in_ready is high whenever no word is in progress, even while a
// result still waits on the output. Default limits are written on the cfg
// port (index 0 double-tap window, index 1 hold threshold); the user must
// write them only while the block is idle, which the block itself does not
// enforce. A zero limit in a key word selects the default.
module key_tap_hold_double_tap_tracker #(
  parameter int POOL_SIZE  = kthdt_pkg::DEF_POOL_SIZE,
  parameter int TIME_WIDTH = kthdt_pkg::DEF_TIME_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kthdt_pkg::in_word_t                  in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kthdt_pkg::out_word_t                 out_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kthdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kthdt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import kthdt_pkg::*;

  localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(POOL_SIZE - 1);

  // Default limits
  logic [MS_W-1:0] dflt_dbl_r;
  logic [MS_W-1:0] dflt_hold_r;

  // Current word
  logic              item_pressed_r;
  logic [CODE_W-1:0] item_code_r;
  logic [MS_W-1:0]   item_dbl_r;
  logic [MS_W-1:0]   item_hold_r;

  // Search results of the first rotation
  logic          found_r,     found_nxt;
  logic [PW-1:0] found_idx_r, found_idx_nxt;
  logic          idle_seen_r, idle_seen_nxt;
  logic [PW-1:0] idle_idx_r,  idle_idx_nxt;

  state_t        state_r, state_nxt;
  logic [PW-1:0] pos_r;
  logic          pos_last;

  // Holding stage and output register
  logic      pend_valid_r;
  out_word_t pend_r;
  logic      out_valid_r;
  out_word_t out_r;

  // Ring
  track_t                rec_q [POOL_SIZE];
  logic [TIME_WIDTH-1:0] el_q  [POOL_SIZE];
  track_t                head_rec;
  track_t                head_rec_upd;
  logic [TIME_WIDTH-1:0] head_el_upd;
  proc_ctl_t             ctl;
  logic                  emit;
  out_word_t             emit_word;

  mode_t mode;
  logic  scanning;
  logic  accept;
  logic  out_free;
  logic  advance;
  logic  push;
  logic  match;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pos_last = (pos_r == POS_LAST);
  assign cfg_ready = 1'b1;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_dbl_r  <= RST_DOUBLE_TAP_MS;
      dflt_hold_r <= RST_HOLD_MS;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DOUBLE_TAP) begin
        dflt_dbl_r <= cfg_data;
      end
      if (cfg_index == REG_HOLD) begin
        dflt_hold_r <= cfg_data;
      end
    end
  end

  // Latch the word, resolving zero limits to the defaults.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_pressed_r <= in_word.key_pressed;
      item_code_r    <= in_word.act_id;
      item_dbl_r     <= (in_word.double_tap_ms != '0) ? in_word.double_tap_ms : dflt_dbl_r;
      item_hold_r    <= (in_word.hold_ms != '0) ? in_word.hold_ms : dflt_hold_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_word.kind == KIND_TICK) ? ST_TICK : ST_SCAN;
        end
      end
      ST_TICK: begin
        if (advance && pos_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (advance && pos_last) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (advance && pos_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    mode     = MODE_PASS;
    scanning = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_TICK: begin
        mode     = MODE_TICK;
        scanning = 1'b1;
      end
      ST_SCAN: begin
        scanning = 1'b1;
      end
      ST_APPLY: begin
        mode     = MODE_APPLY;
        scanning = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the rotation when a new result would overwrite a waiting one.
  assign advance = scanning && !(emit && pend_valid_r && !out_free);
  assign push    = (advance && emit && pend_valid_r)
                || (state_r == ST_FLUSH && pend_valid_r && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (advance) begin
      pos_r <= pos_last ? '0 : pos_r + 1'b1;
    end
  end

  // Search for the tracker of this action and the lowest idle tracker.
  assign match = (head_rec.phase != PH_IDLE) && (head_rec.action == item_code_r);

  always_comb begin
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    idle_seen_nxt = idle_seen_r;
    idle_idx_nxt  = idle_idx_r;
    if (accept) begin
      found_nxt     = 1'b0;
      idle_seen_nxt = 1'b0;
    end else if (state_r == ST_SCAN && advance) begin
      if (match && !found_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = pos_r;
      end
      if (head_rec.phase == PH_IDLE && !idle_seen_r) begin
        idle_seen_nxt = 1'b1;
        idle_idx_nxt  = pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      idle_seen_r <= 1'b0;
    end else begin
      found_r     <= found_nxt;
      idle_seen_r <= idle_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_idx_r <= found_idx_nxt;
    idle_idx_r  <= idle_idx_nxt;
  end

  // Head unit control: the hit picks the tracker to update in the second rotation.
  always_comb begin
    ctl.mode       = mode;
    ctl.found      = found_r;
    ctl.pressed    = item_pressed_r;
    ctl.code       = item_code_r;
    ctl.dbl_limit  = item_dbl_r;
    ctl.hold_limit = item_hold_r;
    ctl.hit        = found_r ? (pos_r == found_idx_r)
                             : (item_pressed_r && idle_seen_r && pos_r == idle_idx_r);
  end

  kthdt_proc #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_proc (
    .ctl         (ctl),
    .rec_i       (rec_q[0]),
    .el_i        (el_q[0]),
    .rec_o       (head_rec_upd),
    .el_o        (head_el_upd),
    .emit_o      (emit),
    .emit_word_o (emit_word)
  );

  assign head_rec = rec_q[0];

  // Ring of cells: each takes its neighbor's record, the tail takes the head's update.
  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    track_t                nb_rec;
    logic [TIME_WIDTH-1:0] nb_el;
    if (i == POOL_SIZE - 1) begin : g_tail
      assign nb_rec = head_rec_upd;
      assign nb_el  = head_el_upd;
    end else begin : g_mid
      assign nb_rec = rec_q[i+1];
      assign nb_el  = el_q[i+1];
    end
    kthdt_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (advance),
      .rec_i (nb_rec),
      .el_i  (nb_el),
      .rec_o (rec_q[i]),
      .el_o  (el_q[i])
    );
  end

  // Holding stage: a key word reports press or release first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (accept) begin
      pend_valid_r <= (in_word.kind == KIND_KEY);
    end else if (advance && emit) begin
      pend_valid_r <= 1'b1;
    end else if (state_r == ST_FLUSH && out_free) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= '{event_code: in_word.act_id,
                  event_kind: in_word.key_pressed ? EV_PRESS : EV_RELEASE,
                  last: 1'b0};
    end else if (advance && emit) begin
      pend_r <= emit_word;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= '{event_code: pend_r.event_code, event_kind: pend_r.event_kind,
                 last: (state_r == ST_FLUSH)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // A new word starts with an empty holding stage.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("holding stage busy while idle");

  // The search rotation always has the press or release waiting.
  a_scan_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> pend_valid_r)
    else $error("key word lost its first result");

  // Every rotation ends with the ring back in tracker order.
  a_flush_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH || state_r == ST_IDLE) |-> (pos_r == '0))
    else $error("ring left out of order");

  // Only the last push of a word carries last.
  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && state_r != ST_FLUSH) |=> (out_valid_r && !out_r.last))
    else $error("last set on a middle result");

endmodule
